FILE: sv/fragment_flow_ring_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Fragment flow ring table: assertion macros
// Concurrent checks on clk with a disable on rst_n; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_FLOW_RING_TABLE_UNIT_DEFINES_SVH
`define FRAGMENT_FLOW_RING_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a consequence in the same cycle.
`define FFRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check a consequence in the following cycle.
`define FFRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFRT_ASSERT_NOW(lbl, ante, cons, msg)
`define FFRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/ffrt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table package
// Field widths, command codes, entry layout, sequencer states and helpers.
// ----------------------------------------------------------------------------
package ffrt_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BUCKET_W = 8;
  localparam int IP_W     = 32;
  localparam int VRF_W    = 16;
  localparam int IDENT_W  = 16;
  localparam int PORT_W   = 16;

  // Default table geometry
  localparam int DEF_NUM_BUCKETS  = 256;
  localparam int DEF_RING_ENTRIES = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic [IP_W-1:0]    src;
    logic [IP_W-1:0]    dst;
    logic [VRF_W-1:0]   vrf;
    logic [IDENT_W-1:0] ident;
  } key_t;

  typedef struct packed {
    key_t              key;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PTR_WAIT,
    ST_ENT_RD,
    ST_ENT_CMP,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // Reduce a bucket index modulo n by conditional subtraction of n shifted.
  function automatic logic [BUCKET_W-1:0] bucket_reduce(input logic [BUCKET_W-1:0] b,
                                                        input int unsigned n);
    int unsigned x;
    int unsigned step;
    x = 32'(b);
    for (int k = BUCKET_W - 1; k >= 0; k--) begin
      step = n << k;
      if (step < (32'd1 << BUCKET_W) && x >= step) begin
        x = x - step;
      end
    end
    return BUCKET_W'(x);
  endfunction

endpackage

FILE: sv/ffrt_in_if.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface ffrt_in_if;
  import ffrt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [BUCKET_W-1:0] bucket;
  logic [IP_W-1:0]     source_addr;
  logic [IP_W-1:0]     dest_addr;
  logic [VRF_W-1:0]    vrf_id;
  logic [IDENT_W-1:0]  datagram_id;
  logic [PORT_W-1:0]   source_port_in;
  logic [PORT_W-1:0]   dest_port_in;

  modport source (
    output valid, command, bucket, source_addr, dest_addr, vrf_id, datagram_id,
           source_port_in, dest_port_in,
    input  ready
  );

  modport sink (
    input  valid, command, bucket, source_addr, dest_addr, vrf_id, datagram_id,
           source_port_in, dest_port_in,
    output ready
  );
endinterface

FILE: sv/ffrt_out_if.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ffrt_out_if;
  import ffrt_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [PORT_W-1:0] source_port_out;
  logic [PORT_W-1:0] dest_port_out;

  modport source (
    output valid, found, source_port_out, dest_port_out,
    input  ready
  );

  modport sink (
    input  valid, found, source_port_out, dest_port_out,
    output ready
  );
endinterface

FILE: sv/ffrt_ram.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read with the data held until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ffrt_match_unit.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table: shared match unit
// Compares the probe key with one stored key and steps a ring position.
// ----------------------------------------------------------------------------
module ffrt_match_unit #(
  parameter int RING_ENTRIES = ffrt_pkg::DEF_RING_ENTRIES
) (
  input  ffrt_pkg::key_t                    probe,
  input  ffrt_pkg::key_t                    stored,
  input  logic [$clog2(RING_ENTRIES)-1:0]   pos,
  output logic                              match,
  output logic [$clog2(RING_ENTRIES)-1:0]   pos_inc
);
  import ffrt_pkg::*;

  localparam int PTR_W = $clog2(RING_ENTRIES);

  // Full 96-bit key compare
  assign match = (probe == stored);

  // Advance around the ring, wrapping after the last slot
  assign pos_inc = (pos == PTR_W'(RING_ENTRIES - 1)) ? '0 : pos + 1'b1;

endmodule

FILE: sv/fragment_flow_ring_table_unit.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table unit
// Bucketed table of circular rings keyed by (src, dst, vrf, ip id); adds,
// looks up and deletes flows with a sequencer over one shared match unit.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  in_item   | in  | valid/ready       | command, bucket, key, ports to store
//  out_item  | out | valid/ready       | found, source/dest port
//
// After accept the sequencer reads the bucket pointers, then for each live entry
// visited (at most RING_ENTRIES-1) reads the entry and compares it; it stops at
// a match or at the end-of-ring check, and makes one update step before the
// result is offered. The unused command skips the entry walk. A new item is
// taken only after the previous result has been taken.
// After reset a clearing pass writes every bucket's pointers with ready low.
// ready is high only while no item is in work; a result holds on the output
// until taken.
// ----------------------------------------------------------------------------
`include "fragment_flow_ring_table_unit_defines.svh"

module fragment_flow_ring_table_unit #(
  parameter int NUM_BUCKETS  = ffrt_pkg::DEF_NUM_BUCKETS,
  parameter int RING_ENTRIES = ffrt_pkg::DEF_RING_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  ffrt_in_if.sink   in_item,
  ffrt_out_if.source out_item
);
  import ffrt_pkg::*;

  localparam int BKT_W     = $clog2(NUM_BUCKETS);
  localparam int PTR_W     = $clog2(RING_ENTRIES);
  localparam int ENT_AW    = BKT_W + PTR_W;
  localparam int ENT_DEPTH = NUM_BUCKETS * (2 ** PTR_W);
  localparam int PAIR_W    = 2 * PTR_W;

  state_t             state_r, state_nxt;
  logic [BKT_W-1:0]   clr_r, clr_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [BKT_W-1:0]   bucket_r, bucket_nxt;
  key_t               key_r, key_nxt;
  logic [PORT_W-1:0]  sport_in_r, sport_in_nxt;
  logic [PORT_W-1:0]  dport_in_r, dport_in_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   next_r, next_nxt;
  logic [PTR_W-1:0]   pos_r, pos_nxt;
  logic               hit_r, hit_nxt;
  logic               found_r, found_nxt;
  logic [PORT_W-1:0]  sport_out_r, sport_out_nxt;
  logic [PORT_W-1:0]  dport_out_r, dport_out_nxt;

  logic               ptr_we, ptr_re;
  logic [BKT_W-1:0]   ptr_waddr, ptr_raddr;
  logic [PAIR_W-1:0]  ptr_wdata, ptr_rdata;

  logic               ent_we, ent_re;
  logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
  entry_t             ent_wdata, ent_rdata;

  key_t               in_key;
  logic [BKT_W-1:0]   in_bucket;
  logic [PTR_W-1:0]   unit_pos, pos_inc, head_inc;
  logic               match;

  // Head and next pointer pair per bucket
  ffrt_ram #(.WIDTH(PAIR_W), .DEPTH(NUM_BUCKETS)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  // Ring entries, addressed by bucket and slot
  ffrt_ram #(.WIDTH(ENTRY_W), .DEPTH(ENT_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Shared compare and ring step: search position, or next on insert
  assign unit_pos = (state_r == ST_UPDATE) ? next_r : pos_r;

  ffrt_match_unit #(.RING_ENTRIES(RING_ENTRIES)) u_match (
    .probe   (key_r),
    .stored  (ent_rdata.key),
    .pos     (unit_pos),
    .match   (match),
    .pos_inc (pos_inc)
  );

  assign head_inc = (head_r == PTR_W'(RING_ENTRIES - 1)) ? '0 : head_r + 1'b1;

  // Map the incoming item
  assign in_key.src   = in_item.source_addr;
  assign in_key.dst   = in_item.dest_addr;
  assign in_key.vrf   = in_item.vrf_id;
  assign in_key.ident = in_item.datagram_id;
  assign in_bucket    = BKT_W'(bucket_reduce(in_item.bucket, NUM_BUCKETS));

  // Handshakes and result
  assign in_item.ready            = (state_r == ST_IDLE);
  assign out_item.valid           = (state_r == ST_RESP);
  assign out_item.found           = found_r;
  assign out_item.source_port_out = sport_out_r;
  assign out_item.dest_port_out   = dport_out_r;

  // Sequencer: next state, datapath and memory controls
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    bucket_nxt    = bucket_r;
    key_nxt       = key_r;
    sport_in_nxt  = sport_in_r;
    dport_in_nxt  = dport_in_r;
    head_nxt      = head_r;
    next_nxt      = next_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    sport_out_nxt = sport_out_r;
    dport_out_nxt = dport_out_r;
    ptr_we        = 1'b0;
    ptr_waddr     = bucket_r;
    ptr_wdata     = '0;
    ptr_re        = 1'b0;
    ptr_raddr     = in_bucket;
    ent_we        = 1'b0;
    ent_waddr     = {bucket_r, pos_r};
    ent_wdata     = '0;
    ent_re        = 1'b0;
    ent_raddr     = {bucket_r, pos_r};

    unique case (state_r)
      ST_CLEAR: begin
        // Empty every ring, one bucket a cycle
        ptr_we    = 1'b1;
        ptr_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Read the bucket pointers as the item is taken
        ptr_re = 1'b1;
        if (in_item.valid) begin
          cmd_nxt      = in_item.command;
          bucket_nxt   = in_bucket;
          key_nxt      = in_key;
          sport_in_nxt = in_item.source_port_in;
          dport_in_nxt = in_item.dest_port_in;
          hit_nxt      = 1'b0;
          state_nxt    = ST_PTR_WAIT;
        end
      end
      ST_PTR_WAIT: begin
        head_nxt = ptr_rdata[PAIR_W-1:PTR_W];
        next_nxt = ptr_rdata[PTR_W-1:0];
        pos_nxt  = ptr_rdata[PAIR_W-1:PTR_W];
        if (cmd_r == CMD_NONE) begin
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_ENT_RD;
        end
      end
      ST_ENT_RD: begin
        // Stop at next, else fetch the entry at the search position
        if (pos_r == next_r) begin
          state_nxt = ST_UPDATE;
        end else begin
          ent_re    = 1'b1;
          state_nxt = ST_ENT_CMP;
        end
      end
      ST_ENT_CMP: begin
        if (match) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = ST_ENT_RD;
        end
      end
      ST_UPDATE: begin
        found_nxt     = hit_r;
        sport_out_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? ent_rdata.sport : '0;
        dport_out_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? ent_rdata.dport : '0;
        if (cmd_r == CMD_ADD) begin
          // Overwrite the match, or insert at next and drop the oldest if full
          ent_we    = 1'b1;
          ent_wdata = '{key: key_r, sport: sport_in_r, dport: dport_in_r};
          if (!hit_r) begin
            ent_waddr = {bucket_r, next_r};
            ptr_we    = 1'b1;
            ptr_wdata = {(pos_inc == head_r) ? head_inc : head_r, pos_inc};
          end
        end else if (cmd_r == CMD_DELETE && hit_r) begin
          // Zero the matching entry in place
          ent_we = 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_item.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    bucket_r    <= bucket_nxt;
    key_r       <= key_nxt;
    sport_in_r  <= sport_in_nxt;
    dport_in_r  <= dport_in_nxt;
    head_r      <= head_nxt;
    next_r      <= next_nxt;
    pos_r       <= pos_nxt;
    found_r     <= found_nxt;
    sport_out_r <= sport_out_nxt;
    dport_out_r <= dport_out_nxt;
  end

  // Checks
  `FFRT_ASSERT_NEXT(a_no_result_after_accept, in_item.valid && in_item.ready, !out_item.valid, "result offered in the cycle after accept")
  `FFRT_ASSERT_NOW(a_ptr_write_on_insert, ptr_we && state_r != ST_CLEAR, cmd_r == CMD_ADD && !hit_r, "pointer write outside an insert")
  `FFRT_ASSERT_NOW(a_compare_live_slot, state_r == ST_ENT_CMP, pos_r != next_r, "compare past the end of the ring")
  `FFRT_ASSERT_NOW(a_unused_cmd_misses, out_item.valid && cmd_r == CMD_NONE, !out_item.found, "unused command reported found")

endmodule

FILE: tb/tb_fragment_flow_ring_table_unit.sv
// ----------------------------------------------------------------------------
// Fragment flow ring table unit testbench
// Drives add, lookup, delete and unused commands through the command channel
// and checks every result against a cycle-free model of the bucket rings.
// A directed opening covers key extremes, updates, deletes and ring overflow;
// random traffic follows on a few hot buckets and a small key pool so that
// rings wrap and keys hit. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_fragment_flow_ring_table_unit;
  import ffrt_pkg::*;

  localparam int NUM_BUCKETS  = DEF_NUM_BUCKETS;
  localparam int RING_ENTRIES = DEF_RING_ENTRIES;
  localparam int RING_W       = $clog2(RING_ENTRIES);
  localparam int RANDOM_CMDS  = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 40;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 200;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [BUCKET_W-1:0] bucket;
    key_t                key;
    logic [PORT_W-1:0]   sport;
    logic [PORT_W-1:0]   dport;
    bit                  wait_drain;
  } flow_cmd_t;

  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } flow_answer_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_TIGHT} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  ffrt_in_if  in_ch ();
  ffrt_out_if out_ch ();

  fragment_flow_ring_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  // Model state of the table
  entry_t            slot_mem [NUM_BUCKETS][RING_ENTRIES];
  logic [RING_W-1:0] head_ptr [NUM_BUCKETS];
  logic [RING_W-1:0] next_ptr [NUM_BUCKETS];

  flow_cmd_t    pending_cmds[$];
  flow_answer_t predicted_answers[$];

  bit       cmd_taken;
  bit       offering;
  int       gap_left;
  int       burst_left;
  int       answers_seen;
  int       mismatches;
  int       cycle_count;
  int       hold_left;
  bit       hold_done;
  int       mode_left;
  rx_mode_t rx_mode;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [RING_W-1:0] ring_step(logic [RING_W-1:0] p);
    return (p == RING_W'(RING_ENTRIES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one command to the model table and return its answer
  function automatic flow_answer_t table_apply(flow_cmd_t c);
    flow_answer_t      ans;
    logic [RING_W-1:0] pos;
    logic [RING_W-1:0] hit_pos;
    logic [RING_W-1:0] nx;
    bit                hit;
    int                b;
    ans = '0;
    hit = 1'b0;
    hit_pos = '0;
    b = int'(c.bucket) % NUM_BUCKETS;
    pos = head_ptr[b];
    // search live entries from head up to next
    for (int n = 0; n < RING_ENTRIES && pos != next_ptr[b] && !hit; n++) begin
      if (slot_mem[b][pos].key == c.key) begin
        hit = 1'b1;
        hit_pos = pos;
      end else begin
        pos = ring_step(pos);
      end
    end
    case (c.command)
      CMD_ADD: begin
        if (hit) begin
          slot_mem[b][hit_pos].sport = c.sport;
          slot_mem[b][hit_pos].dport = c.dport;
          ans.found = 1'b1;
        end else begin
          nx = next_ptr[b];
          slot_mem[b][nx] = '{key: c.key, sport: c.sport, dport: c.dport};
          nx = ring_step(nx);
          next_ptr[b] = nx;
          // full ring: drop the oldest entry
          if (nx == head_ptr[b]) head_ptr[b] = ring_step(head_ptr[b]);
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          ans.found = 1'b1;
          ans.sport = slot_mem[b][hit_pos].sport;
          ans.dport = slot_mem[b][hit_pos].dport;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          slot_mem[b][hit_pos] = '0;
          ans.found = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic key_t make_key(logic [IP_W-1:0] s, logic [IP_W-1:0] d,
                                    logic [VRF_W-1:0] v, logic [IDENT_W-1:0] i);
    key_t k;
    k.src = s;
    k.dst = d;
    k.vrf = v;
    k.ident = i;
    return k;
  endfunction

  function automatic key_t random_key();
    return make_key($urandom(), $urandom(), VRF_W'($urandom_range(0, 65535)),
                    IDENT_W'($urandom_range(0, 65535)));
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [BUCKET_W-1:0] b, key_t k,
                           logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp,
                           bit drain = 1'b0);
    flow_cmd_t c;
    c.command = cmd;
    c.bucket = b;
    c.key = k;
    c.sport = sp;
    c.dport = dp;
    c.wait_drain = drain;
    pending_cmds.push_back(c);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    flow_cmd_t    seen;
    flow_answer_t want;
    if (rst_n) begin
      // predict the answer of an accepted command
      if (in_ch.valid && in_ch.ready) begin
        seen.command = in_ch.command;
        seen.bucket = in_ch.bucket;
        seen.key = make_key(in_ch.source_addr, in_ch.dest_addr, in_ch.vrf_id,
                            in_ch.datagram_id);
        seen.sport = in_ch.source_port_in;
        seen.dport = in_ch.dest_port_in;
        seen.wait_drain = 1'b0;
        predicted_answers.push_back(table_apply(seen));
        cmd_taken = 1'b1;
      end
      // compare an accepted result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        if (predicted_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result found=%0d sport=%h dport=%h", $time,
                     out_ch.found, out_ch.source_port_out, out_ch.dest_port_out);
        end else begin
          want = predicted_answers.pop_front();
          if (out_ch.found !== want.found || out_ch.source_port_out !== want.sport ||
              out_ch.dest_port_out !== want.dport) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected found=%0d sport=%h dport=%h, got found=%0d sport=%h dport=%h",
                       $time, want.found, want.sport, want.dport, out_ch.found,
                       out_ch.source_port_out, out_ch.dest_port_out);
          end
        end
      end
    end
  end

  // Command driver: bursts with random gaps, optional drain before an item
  always @(negedge clk) begin
    if (rst_n) begin
      if (cmd_taken) begin
        void'(pending_cmds.pop_front());
        cmd_taken = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     (!pending_cmds[0].wait_drain || predicted_answers.size() == 0)) begin
          offering = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      if (offering) begin
        in_ch.command        <= pending_cmds[0].command;
        in_ch.bucket         <= pending_cmds[0].bucket;
        in_ch.source_addr    <= pending_cmds[0].key.src;
        in_ch.dest_addr      <= pending_cmds[0].key.dst;
        in_ch.vrf_id         <= pending_cmds[0].key.vrf;
        in_ch.datagram_id    <= pending_cmds[0].key.ident;
        in_ch.source_port_in <= pending_cmds[0].sport;
        in_ch.dest_port_in   <= pending_cmds[0].dport;
      end
      in_ch.valid <= offering;
    end
  end

  // Result receiver: stall pattern plus one long hold-off
  always @(negedge clk) begin
    bit take;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!hold_done && answers_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        take = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: take = 1'b1;
          RX_HALF: take = ($urandom_range(0, 1) == 1);
          default: take = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_ch.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    key_t             key_pool[32];
    logic [BUCKET_W-1:0] hot_buckets[6];
    key_t             zero_key;
    key_t             ones_key;
    key_t             k;
    logic [CMD_W-1:0] cmd;
    logic [BUCKET_W-1:0] b;
    int               r;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_NONE;
    in_ch.bucket = '0;
    in_ch.source_addr = '0;
    in_ch.dest_addr = '0;
    in_ch.vrf_id = '0;
    in_ch.datagram_id = '0;
    in_ch.source_port_in = '0;
    in_ch.dest_port_in = '0;
    out_ch.ready = 1'b0;
    cmd_taken = 1'b0;
    offering = 1'b0;
    gap_left = 0;
    burst_left = 0;
    answers_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode_left = 0;
    rx_mode = RX_OPEN;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      head_ptr[i] = '0;
      next_ptr[i] = '0;
      for (int j = 0; j < RING_ENTRIES; j++) slot_mem[i][j] = '0;
    end

    zero_key = '0;
    ones_key = '1;

    // Directed: empty miss, key extremes, update, delete, unused command
    queue_cmd(CMD_LOOKUP, 8'd0, zero_key, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 8'd0, zero_key, 16'h1234, 16'hABCD);
    queue_cmd(CMD_LOOKUP, 8'd0, zero_key, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 8'd255, ones_key, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_LOOKUP, 8'd255, ones_key, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 8'd255, ones_key, 16'h0000, 16'h0000);
    queue_cmd(CMD_LOOKUP, 8'd255, ones_key, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_DELETE, 8'd255, ones_key, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_DELETE, 8'd255, ones_key, 16'h0000, 16'h0000);
    // a deleted entry keeps its slot with an all-zero key
    queue_cmd(CMD_LOOKUP, 8'd255, zero_key, 16'h0000, 16'h0000);
    queue_cmd(CMD_NONE, 8'd255, ones_key, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_NONE, 8'd0, zero_key, 16'h0000, 16'h0000);
    // overflow one ring so the oldest entry drops
    for (int i = 0; i < RING_ENTRIES; i++)
      queue_cmd(CMD_ADD, 8'd7, make_key(32'hC0A8_0000 + i, 32'h0A00_0001, 16'd7, 16'(i)),
                16'(100 + i), 16'(200 + i));
    queue_cmd(CMD_LOOKUP, 8'd7, make_key(32'hC0A8_0000, 32'h0A00_0001, 16'd7, 16'd0),
              16'h0000, 16'h0000);
    queue_cmd(CMD_LOOKUP, 8'd7, make_key(32'hC0A8_0001, 32'h0A00_0001, 16'd7, 16'd1),
              16'h0000, 16'h0000);

    // Random: hot buckets and a small key pool so rings wrap and keys recur
    for (int i = 0; i < 32; i++) key_pool[i] = random_key();
    key_pool[0] = zero_key;
    for (int i = 0; i < 6; i++) hot_buckets[i] = BUCKET_W'($urandom_range(0, 255));
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_ADD;
      else if (r < 75) cmd = CMD_LOOKUP;
      else if (r < 95) cmd = CMD_DELETE;
      else cmd = CMD_NONE;
      b = ($urandom_range(0, 9) < 7) ? hot_buckets[$urandom_range(0, 5)]
                                     : BUCKET_W'($urandom_range(0, 255));
      k = ($urandom_range(0, 4) == 0) ? random_key() : key_pool[$urandom_range(0, 31)];
      queue_cmd(cmd, b, k, PORT_W'($urandom_range(0, 65535)),
                PORT_W'($urandom_range(0, 65535)), (i == 700 || i == 1300));
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all commands sent, all answers in, then let the pipe settle
    do @(posedge clk);
    while (pending_cmds.size() > 0 || offering || predicted_answers.size() > 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && predicted_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ffrt_pkg.sv
sv/ffrt_in_if.sv
sv/ffrt_out_if.sv
sv/ffrt_ram.sv
sv/ffrt_match_unit.sv
sv/fragment_flow_ring_table_unit.sv
tb/tb_fragment_flow_ring_table_unit.sv
